FILE: rtl/ps2s1_pkg.sv
// ----------------------------------------------------------------------------
// ps2s1_pkg
// Shared widths, scan code constants and the modifier lookup for the
// scan code set 1 modifier tracker.
// ----------------------------------------------------------------------------
package ps2s1_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CodeW = 7;
    localparam int unsigned ModW  = 8;

    // prefix bytes
    localparam logic [ByteW-1:0] ScPrefixE0 = 8'hE0;
    localparam logic [ByteW-1:0] ScPrefixE1 = 8'hE1;

    // key codes with modifier meaning
    localparam logic [CodeW-1:0] KcCtrl   = 7'h1D;
    localparam logic [CodeW-1:0] KcAlt    = 7'h38;
    localparam logic [CodeW-1:0] KcLShift = 7'h2A;
    localparam logic [CodeW-1:0] KcRShift = 7'h36;
    localparam logic [CodeW-1:0] KcLWin   = 7'h5B;
    localparam logic [CodeW-1:0] KcRWin   = 7'h5C;
    localparam logic [CodeW-1:0] KcMenu   = 7'h5D;
    localparam logic [CodeW-1:0] KcCaps   = 7'h3A;
    localparam logic [CodeW-1:0] KcScroll = 7'h46;
    localparam logic [CodeW-1:0] KcNum    = 7'h45;

    // modifier bit masks
    localparam logic [ModW-1:0] ModCtrl   = 8'h01;
    localparam logic [ModW-1:0] ModAlt    = 8'h02;
    localparam logic [ModW-1:0] ModShift  = 8'h04;
    localparam logic [ModW-1:0] ModWin    = 8'h08;
    localparam logic [ModW-1:0] ModMenu   = 8'h10;
    localparam logic [ModW-1:0] ModCaps   = 8'h20;
    localparam logic [ModW-1:0] ModNum    = 8'h40;
    localparam logic [ModW-1:0] ModScroll = 8'h80;
    localparam logic [ModW-1:0] ModNone   = 8'h00;

    // one result word
    typedef struct packed {
        logic             key_valid;
        logic [CodeW-1:0] key_code;
        logic             key_repeat;
        logic [ModW-1:0]  modifier_bits;
    } t_key_word;

    // modifier lookup: mask under the prefix rules, plus lock flag
    typedef struct packed {
        logic [ModW-1:0] mask;
        logic            lock;
    } t_mod_info;

    function automatic t_mod_info mod_lookup(input logic [CodeW-1:0] code,
                                             input logic ext);
        t_mod_info info;
        info.mask = ModNone;
        info.lock = 1'b0;
        case (code)
            KcCtrl:   info.mask = ModCtrl;
            KcAlt:    info.mask = ModAlt;
            KcLShift,
            KcRShift: info.mask = ext ? ModNone : ModShift;
            KcLWin,
            KcRWin:   info.mask = ext ? ModWin : ModNone;
            KcMenu:   info.mask = ext ? ModMenu : ModNone;
            KcCaps: begin
                info.lock = 1'b1;
                info.mask = ext ? ModNone : ModCaps;
            end
            KcScroll: begin
                info.lock = 1'b1;
                info.mask = ext ? ModNone : ModScroll;
            end
            KcNum: begin
                info.lock = 1'b1;
                info.mask = ext ? ModNone : ModNum;
            end
            default: begin
                info.mask = ModNone;
                info.lock = 1'b0;
            end
        endcase
        return info;
    endfunction

endpackage

FILE: rtl/ps2s1_if.sv
// ----------------------------------------------------------------------------
// ps2s1 channel interfaces
// Valid/ready channels for scan bytes in and decoded key words out.
// ----------------------------------------------------------------------------
interface ps2s1_byte_if import ps2s1_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2s1_key_if import ps2s1_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             key_valid;
    logic [CodeW-1:0] key_code;
    logic             key_repeat;
    logic [ModW-1:0]  modifier_bits;

    modport source (output valid, output key_valid, output key_code,
                    output key_repeat, output modifier_bits, input ready);
    modport sink   (input valid, input key_valid, input key_code,
                    input key_repeat, input modifier_bits, output ready);
endinterface

FILE: rtl/ps2_set1_modifier_tracker_core.sv
// ----------------------------------------------------------------------------
// ps2_set1_modifier_tracker_core
// Tracks modifiers, extended prefix and held key from PS/2 set 1 bytes.
// ----------------------------------------------------------------------------
// Takes one scan code set 1 byte per word and returns one key word per byte,
// in order. Each byte is decoded combinationally against the modifier,
// prefix and held-key registers, and the result lands in an output register.
// A new byte is taken every cycle while the output register is empty or being
// drained, so the sustained rate is one byte per clock. Prefix bytes (E0, E1)
// only arm the extended flag; a make of the held key is flagged as a repeat
// and leaves the modifiers alone; lock keys toggle on make; a break clears
// the held key if it matches, and its modifier unless it is a lock key.
// modifier_bits always shows the modifier state after that byte.
module ps2_set1_modifier_tracker_core import ps2s1_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ps2s1_byte_if.sink         i_scan,
    ps2s1_key_if.source        o_key
);

    // state registers
    logic [ModW-1:0]  r_mod,   n_mod;
    logic             r_pre,   n_pre;
    logic [CodeW-1:0] r_held,  n_held;

    // output register
    logic             r_out_valid;
    t_key_word        r_out, n_out;

    logic             w_accept;
    logic [CodeW-1:0] w_code;
    logic             w_is_prefix;
    logic             w_is_break;
    logic             w_is_repeat;
    t_mod_info        w_info;

    // handshake: take a byte whenever the result slot frees up
    assign i_scan.ready = !r_out_valid || o_key.ready;
    assign w_accept     = i_scan.valid && i_scan.ready;

    // byte classification
    assign w_code      = i_scan.scan_byte[CodeW-1:0];
    assign w_is_prefix = (i_scan.scan_byte == ScPrefixE0) ||
                         (i_scan.scan_byte == ScPrefixE1);
    assign w_is_break  = i_scan.scan_byte[ByteW-1];
    assign w_is_repeat = (r_held != '0) && (r_held == w_code);
    assign w_info      = mod_lookup(w_code, r_pre);

    // next state and result word
    always_comb begin
        n_mod  = r_mod;
        n_pre  = 1'b0;
        n_held = r_held;
        n_out.key_valid  = 1'b0;
        n_out.key_code   = '0;
        n_out.key_repeat = 1'b0;
        if (w_is_prefix) begin
            n_pre = 1'b1;
        end else if (w_is_break) begin
            if (r_held == w_code) begin
                n_held = '0;
            end
            if (!w_info.lock) begin
                n_mod = r_mod & ~w_info.mask;
            end
        end else if (w_is_repeat) begin
            n_out.key_valid  = 1'b1;
            n_out.key_code   = w_code;
            n_out.key_repeat = 1'b1;
        end else begin
            n_held          = w_code;
            n_out.key_valid = 1'b1;
            n_out.key_code  = w_code;
            if (w_info.lock) begin
                n_mod = r_mod ^ w_info.mask;
            end else begin
                n_mod = r_mod | w_info.mask;
            end
        end
        n_out.modifier_bits = n_mod;
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod       <= '0;
            r_pre       <= 1'b0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_mod  <= n_mod;
                r_pre  <= n_pre;
                r_held <= n_held;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_key.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    // output drive
    assign o_key.valid         = r_out_valid;
    assign o_key.key_valid     = r_out.key_valid;
    assign o_key.key_code      = r_out.key_code;
    assign o_key.key_repeat    = r_out.key_repeat;
    assign o_key.modifier_bits = r_out.modifier_bits;

`ifndef ASSERT_OFF
    // a prefix byte arms the extended flag
    a_prefix_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_is_prefix |=> r_pre)
        else $error("prefix flag not set after prefix byte");

    // any other byte clears the extended flag
    a_prefix_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_is_prefix |=> !r_pre)
        else $error("prefix flag survived a non-prefix byte");

    // a reported key is the held key
    a_key_is_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.key_valid |-> r_held == r_out.key_code)
        else $error("reported key differs from held key");

    // pending word shows the current modifier state
    a_mod_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.modifier_bits == r_mod)
        else $error("modifier bits out of step with modifier register");

    // a repeat is always a valid key and leaves modifiers untouched
    a_repeat_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_is_prefix && !w_is_break && w_is_repeat
        |=> r_out.key_valid && r_out.key_repeat && r_mod == $past(r_mod))
        else $error("repeat changed modifiers or lost key flag");
`endif

endmodule
